// ===== design/cmds_pkg.sv =====
// Package: shared types and constants for the centroid mean-distance sphere block.
package cmds_pkg;

   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 32;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
      logic                      last_vertex;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RADIUS_W-1:0]       radius;
      logic                      overflowed;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RD,
      ST_RD_WAIT,
      ST_SQ,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_ACC,
      ST_RAD_START,
      ST_RAD_WAIT,
      ST_OUT
   } state_type;

endpackage

// ===== design/cmds_if.sv =====
// Interfaces: valid/ready channels for vertex requests and sphere responses.
interface cmds_req_if;
   import cmds_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cmds_rsp_if;
   import cmds_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cmds_div.sv =====
// Module: restoring divider, one quotient bit per cycle; rounding comes from a bias in the numerator.
module cmds_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
      if (start) begin
         // numerator already carries the rounding bias
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

   busy_counts: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("divider not busy after start");
   cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count underrun");
endmodule

// ===== design/cmds_sqrt.sv =====
// Module: bit-serial integer square root of a 66-bit value, one root bit per cycle.
module cmds_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] value,
   output logic        busy,
   output logic [32:0] root
);
   logic [65:0] val_ff, val_in;
   logic [34:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] rsh, trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rsh     = {rem_ff[32:0], val_ff[65:64]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[63:0], 2'b00};
         if (rsh >= trial) begin
            rem_in  = rsh - trial;
            root_in = {root_ff[31:0], 1'b1};
         end else begin
            rem_in  = rsh;
            root_in = {root_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

   sqrt_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("sqrt not busy after start");
   sqrt_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 6'd33) else $error("sqrt count out of range");
endmodule

// ===== design/centroid_mean_distance_sphere.sv =====
// Top level: centroid and mean-distance bounding sphere over a stored vertex set.
//
//  channel | dir | payload
//  req     | in  | vertex_x/y/z Q16.16, last_vertex
//  rsp     | out | center_x/y/z Q16.16, radius UQ16.16, overflowed
//
// A vertex without last_vertex is taken back to back. On the last vertex the block
// runs three centroid divisions (64 quotient bits each), then per stored vertex a
// registered memory read (RD, RD_WAIT), a squaring pass on one 33x33 multiplier
// and a 33-bit square root, and finally the radius divide and the response.
// Synchronous reset clears sums, count and flags; the vertex memory is not cleared.
// The response stays valid until taken; req is not ready meanwhile.
module centroid_mean_distance_sphere #(
   parameter int MAX_VERTICES = 1024
) (
   input logic clock,
   input logic reset,
   cmds_req_if.sink   req,
   cmds_rsp_if.source rsp
);
   import cmds_pkg::*;

   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W  = COORD_W + CNT_W;
   localparam int DIV_W  = 64;

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_z [MAX_VERTICES];
   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff, rd_z_ff;

   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    dropped_ff;
   logic [ADDR_W-1:0]       idx_ff;
   logic [1:0]              axis_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [65:0]             sq_acc_ff;
   logic [DIV_W-1:0]        dsum_ff;
   logic [RADIUS_W-1:0]     radius_ff;
   logic                    wr_ok;
   logic                    req_fire, rsp_fire;

   // shared divider
   logic             div_start, div_busy;
   logic [DIV_W-1:0] div_num, div_quot;
   logic             div_neg_ff;
   // single square root, reused for every vertex
   logic             sq_start, sq_busy;
   logic [32:0]      sq_root;

   logic signed [SUM_W-1:0] cur_sum;
   logic [SUM_W-1:0]        mag;
   logic signed [COORD_W:0] diff;
   logic [32:0]             adiff;
   logic [65:0]             prod;

   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign wr_ok     = count_ff < CNT_W'(MAX_VERTICES);
   assign req.ready = (state_ff == ST_LOAD);

   always_comb begin
      unique case (axis_ff)
         2'd0:    cur_sum = sum_x_ff;
         2'd1:    cur_sum = sum_y_ff;
         default: cur_sum = sum_z_ff;
      endcase
      mag = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
      unique case (axis_ff)
         2'd0:    diff = {rd_x_ff[COORD_W-1], rd_x_ff} - {cx_ff[COORD_W-1], cx_ff};
         2'd1:    diff = {rd_y_ff[COORD_W-1], rd_y_ff} - {cy_ff[COORD_W-1], cy_ff};
         default: diff = {rd_z_ff[COORD_W-1], rd_z_ff} - {cz_ff[COORD_W-1], cz_ff};
      endcase
      adiff = diff[COORD_W] ? 33'(-diff) : 33'(diff);
   end

   always_ff @(posedge clock) prod <= adiff * adiff;

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      sq_start  = 1'b0;
      if (state_ff == ST_DIV_START) begin
         div_start = 1'b1;
         div_num   = DIV_W'(mag) + DIV_W'(count_ff >> 1);
      end else if (state_ff == ST_RAD_START) begin
         div_start = 1'b1;
         div_num   = dsum_ff + DIV_W'(count_ff >> 1);
      end
      if (state_ff == ST_SQRT_START) sq_start = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:       if (req_fire && req.data.last_vertex) state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (!div_busy) state_in = (axis_ff == 2'd2) ? ST_RD : ST_DIV_START;
         ST_RD:         state_in = ST_RD_WAIT;
         ST_RD_WAIT:    state_in = ST_SQ;
         ST_SQ:         if (axis_ff == 2'd3) state_in = ST_SQRT_START;
         ST_SQRT_START: state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT:  if (!sq_busy) state_in = ST_ACC;
         ST_ACC:        state_in = ({1'b0, idx_ff} == (count_ff - 1'b1)) ? ST_RAD_START : ST_RD;
         ST_RAD_START:  state_in = ST_RAD_WAIT;
         ST_RAD_WAIT:   if (!div_busy) state_in = ST_OUT;
         ST_OUT:        if (rsp_fire) state_in = ST_LOAD;
         default:       state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && wr_ok) begin
         mem_x[ADDR_W'(count_ff)] <= req.data.vertex_x;
         mem_y[ADDR_W'(count_ff)] <= req.data.vertex_y;
         mem_z[ADDR_W'(count_ff)] <= req.data.vertex_z;
      end
      if (state_ff == ST_RD) begin
         rd_x_ff <= mem_x[idx_ff];
         rd_y_ff <= mem_y[idx_ff];
         rd_z_ff <= mem_z[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         sum_z_ff   <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         axis_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_LOAD: if (req_fire) begin
               if (wr_ok) begin
                  sum_x_ff <= sum_x_ff + SUM_W'(req.data.vertex_x);
                  sum_y_ff <= sum_y_ff + SUM_W'(req.data.vertex_y);
                  sum_z_ff <= sum_z_ff + SUM_W'(req.data.vertex_z);
                  count_ff <= count_ff + 1'b1;
               end else begin
                  dropped_ff <= 1'b1;
               end
               axis_ff <= '0;
               idx_ff  <= '0;
            end
            ST_DIV_START: div_neg_ff <= cur_sum[SUM_W-1];
            ST_DIV_WAIT: if (!div_busy) begin
               unique case (axis_ff)
                  2'd0:    cx_ff <= div_neg_ff ? -COORD_W'(div_quot) : COORD_W'(div_quot);
                  2'd1:    cy_ff <= div_neg_ff ? -COORD_W'(div_quot) : COORD_W'(div_quot);
                  default: cz_ff <= div_neg_ff ? -COORD_W'(div_quot) : COORD_W'(div_quot);
               endcase
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
               dsum_ff <= '0;
            end
            ST_RD_WAIT: begin
               sq_acc_ff <= '0;
               axis_ff   <= 2'd0;
            end
            ST_SQ: begin
               // prod is registered, so it holds the product for the previous axis
               if (axis_ff != 2'd0) sq_acc_ff <= sq_acc_ff + prod;
               axis_ff <= axis_ff + 1'b1;
            end
            ST_ACC: begin
               dsum_ff <= dsum_ff + DIV_W'(sq_root);
               idx_ff  <= idx_ff + 1'b1;
            end
            ST_RAD_WAIT: if (!div_busy)
               radius_ff <= (div_quot[DIV_W-1:RADIUS_W] != '0) ? '1 : div_quot[RADIUS_W-1:0];
            ST_OUT: if (rsp_fire) begin
               sum_x_ff   <= '0;
               sum_y_ff   <= '0;
               sum_z_ff   <= '0;
               count_ff   <= '0;
               dropped_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   cmds_div #(.NUM_W(DIV_W), .DEN_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(count_ff), .busy(div_busy), .quot(div_quot)
   );

   cmds_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_acc_ff),
      .busy(sq_busy), .root(sq_root)
   );

   assign rsp.valid           = (state_ff == ST_OUT);
   assign rsp.data.center_x   = cx_ff;
   assign rsp.data.center_y   = cy_ff;
   assign rsp.data.center_z   = cz_ff;
   assign rsp.data.radius     = radius_ff;
   assign rsp.data.overflowed = dropped_ff;

   cnt_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES)) else $error("vertex count above capacity");
   no_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_START |-> count_ff != '0) else $error("compute on empty set");
   out_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> count_ff == '0 && !dropped_ff) else $error("set state not cleared");
   walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> {1'b0, idx_ff} < count_ff) else $error("walk past stored set");
endmodule
